// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent checks on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define BBD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbd check failed");

// Next-cycle implication
`define BBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbd check failed");

`endif

// File: rtl/bbd_pkg.sv
// ----------------------------------------------------------------------------
// Bayer demosaic package
// Shared constants, types and the bilinear interpolation function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbd_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int WIDTH_RESET  = 424;
	localparam int HEIGHT_RESET = 636;
	localparam int MIN_DIM      = 2;
	localparam int PIX_W        = 8;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	// Result queue holds pairs of results
	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);
	// Accept only while two more pairs fit (one in flight, one entering)
	localparam int RES_ROOM  = RES_DEPTH - 2;

	// Input item kinds
	localparam logic KIND_RAW   = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Register indexes (byte address bit 2)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} wcol_t;

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} rgb_t;

	typedef struct packed {
		rgb_t color;
		logic end_of_line;
		logic end_of_frame;
	} res_t;

	// Results caused by one input item; r1 only meaningful when two is set
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} res_pair_t;

	// Work carried from the accept stage to the window stage
	typedef struct packed {
		logic             wr;
		logic             row0;
		logic             adv;
		logic             fill;
		logic             two;
		logic             drain;
		logic             odd_row;
		logic             odd_col;
		logic [COL_W-1:0] addr;
		pix_t             sample;
	} ctl_t;

	// Bilinear reconstruction of the center pixel of a 3x3 window (RGGB)
	function automatic rgb_t interp(wcol_t a, wcol_t b, wcol_t c,
					logic odd_row, logic odd_col);
		logic [PIX_W+1:0] cross_sum;
		logic [PIX_W+1:0] diag_sum;
		logic [PIX_W:0]   horiz_sum;
		logic [PIX_W:0]   vert_sum;
		pix_t             cross_v;
		pix_t             diag_v;
		pix_t             horiz_v;
		pix_t             vert_v;
		rgb_t             res;
		cross_sum = (PIX_W+2)'(b.top) + (PIX_W+2)'(b.bot) + (PIX_W+2)'(a.mid)
			+ (PIX_W+2)'(c.mid) + (PIX_W+2)'(2);
		diag_sum  = (PIX_W+2)'(a.top) + (PIX_W+2)'(c.top) + (PIX_W+2)'(a.bot)
			+ (PIX_W+2)'(c.bot) + (PIX_W+2)'(2);
		horiz_sum = (PIX_W+1)'(a.mid) + (PIX_W+1)'(c.mid) + (PIX_W+1)'(1);
		vert_sum  = (PIX_W+1)'(b.top) + (PIX_W+1)'(b.bot) + (PIX_W+1)'(1);
		cross_v = cross_sum[PIX_W+1:2];
		diag_v  = diag_sum[PIX_W+1:2];
		horiz_v = horiz_sum[PIX_W:1];
		vert_v  = vert_sum[PIX_W:1];
		unique case ({odd_row, odd_col})
			2'b00: begin
				res = '{red: b.mid, green: cross_v, blue: diag_v};
			end
			2'b11: begin
				res = '{red: diag_v, green: cross_v, blue: b.mid};
			end
			2'b01: begin
				res = '{red: horiz_v, green: b.mid, blue: vert_v};
			end
			default: begin
				res = '{red: vert_v, green: b.mid, blue: horiz_v};
			end
		endcase
		return res;
	endfunction

endpackage

// File: rtl/bbd_ifs.sv
// ----------------------------------------------------------------------------
// Bayer demosaic stream interfaces
// Raw sample channel and RGB result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bbd_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	bbd_pkg::pix_t      raw_sample;

	modport source (output valid, output kind, output raw_sample, input ready);
	modport sink (input valid, input kind, input raw_sample, output ready);
endinterface

interface bbd_out_if;
	logic               valid;
	logic               ready;
	bbd_pkg::pix_t      red;
	bbd_pkg::pix_t      green;
	bbd_pkg::pix_t      blue;
	logic               end_of_line;
	logic               end_of_frame;

	modport source (output valid, output red, output green, output blue,
			output end_of_line, output end_of_frame, input ready);
	modport sink (input valid, input red, input green, input blue,
			input end_of_line, input end_of_frame, output ready);
endinterface

// File: rtl/bayer_bilinear_demosaic.sv
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic
// RGGB raw stream in, RGB per pixel out, 3x3 window over two line stores.
// ----------------------------------------------------------------------------
// Takes one raw sample or drain tick per cycle while ready is high. The
// result for pixel (r-1,c-1) follows the transfer of sample (r,c) through the
// registered line-store read and then the window update into the result
// queue. The last sample of a row yields two results; row 0 yields none;
// after the last row, image_width drain ticks flush the final row. The rate
// is one item per cycle, set by the single read/write port pair of each line
// store; ready falls only when the result queue holds more than two pairs.
// Line stores are 1024x8 RAMs with no clearing pass; image_width and
// image_height are clamped to [2,1024] and [2,4096], and writing either one
// restarts the frame position.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bayer_bilinear_demosaic (
	input  logic                           clk,
	input  logic                           arst_n,
	bbd_in_if.sink                         bayer,
	bbd_out_if.source                      rgb,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bbd_pkg::APB_AW-1:0]     paddr,
	input  logic [bbd_pkg::APB_DW-1:0]     pwdata,
	output logic [bbd_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);
	import bbd_pkg::*;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WIDTH_REG_W-1:0]  w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic                    cfg_wr;

	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        drain_q;
	logic                    draining_q;

	logic                    acc;
	logic                    raw_ok;
	logic                    drn_ok;
	logic                    col_last;
	logic                    drain_last;
	logic                    row_last;
	logic [COL_W-1:0]        pos;
	logic [COL_W-1:0]        rd_addr;
	ctl_t                    ctl_d;

	logic                    valid_s1;
	ctl_t                    ctl_s1;
	pix_t                    old_rd_s1;
	pix_t                    new_rd_s1;

	pix_t                    older_mem [MAX_WIDTH];
	pix_t                    newer_mem [MAX_WIDTH];

	wcol_t [2:0]             win_q;
	wcol_t                   ncol;
	res_pair_t               pair;
	logic                    push;
	logic [RES_CNT_W-1:0]    level;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH: begin
				prdata = APB_DW'(width_q);
			end
			default: begin
				prdata = APB_DW'(height_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(WIDTH_RESET);
			height_q <= HEIGHT_REG_W'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH: begin
					width_q <= pwdata[WIDTH_REG_W-1:0];
				end
				default: begin
					height_q <= pwdata[HEIGHT_REG_W-1:0];
				end
			endcase
		end
	end

	// Clamp frame size
	always_comb begin
		priority if (width_q < WIDTH_REG_W'(MIN_DIM)) begin
			w_eff = WIDTH_REG_W'(MIN_DIM);
		end else if (width_q > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		priority if (height_q < HEIGHT_REG_W'(MIN_DIM)) begin
			h_eff = HEIGHT_REG_W'(MIN_DIM);
		end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Decode the incoming item
	assign bayer.ready = (level <= RES_CNT_W'(RES_ROOM));
	assign acc        = bayer.valid && bayer.ready;
	assign raw_ok     = (bayer.kind == KIND_RAW) && !draining_q;
	assign drn_ok     = (bayer.kind == KIND_DRAIN) && draining_q;
	assign col_last   = (WIDTH_REG_W'(col_q) == w_eff - 1'b1);
	assign drain_last = (WIDTH_REG_W'(drain_q) == w_eff - 1'b1);
	assign row_last   = (HEIGHT_REG_W'(row_q) == h_eff - 1'b1);
	assign pos        = draining_q ? drain_q : col_q;
	assign rd_addr    = pos;

	always_comb begin
		ctl_d.wr      = raw_ok;
		ctl_d.row0    = (row_q == '0);
		ctl_d.adv     = drn_ok || (raw_ok && (row_q != '0));
		ctl_d.fill    = (pos == '0);
		ctl_d.two     = draining_q ? drain_last : col_last;
		ctl_d.drain   = drn_ok;
		ctl_d.odd_row = draining_q ? !h_eff[0] : !row_q[0];
		ctl_d.odd_col = pos[0];
		ctl_d.addr    = pos;
		ctl_d.sample  = bayer.raw_sample;
	end

	// Frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (cfg_wr) begin
			col_q      <= '0;
			row_q      <= '0;
			drain_q    <= '0;
			draining_q <= 1'b0;
		end else if (acc && raw_ok) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q      <= '0;
					drain_q    <= '0;
					draining_q <= 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (acc && drn_ok) begin
			if (drain_last) begin
				drain_q    <= '0;
				draining_q <= 1'b0;
			end else begin
				drain_q <= drain_q + 1'b1;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc && (raw_ok || drn_ok) && !cfg_wr;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_d;
	end

	// Line stores: read on accept, write back in stage 1
	always_ff @(posedge clk) begin
		old_rd_s1 <= older_mem[rd_addr];
		if (valid_s1 && ctl_s1.wr) begin
			older_mem[ctl_s1.addr] <= ctl_s1.row0 ? ctl_s1.sample : new_rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		new_rd_s1 <= newer_mem[rd_addr];
		if (valid_s1 && ctl_s1.wr) begin
			newer_mem[ctl_s1.addr] <= ctl_s1.sample;
		end
	end

	// New window column; drain replicates the last row downward
	assign ncol.top = old_rd_s1;
	assign ncol.mid = new_rd_s1;
	assign ncol.bot = ctl_s1.drain ? new_rd_s1 : ctl_s1.sample;

	// Shift the window, twice at the end of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1 && ctl_s1.adv) begin
			priority if (ctl_s1.fill) begin
				win_q[0] <= ncol;
				win_q[1] <= ncol;
				win_q[2] <= ncol;
			end else if (ctl_s1.two) begin
				win_q[0] <= win_q[2];
				win_q[1] <= ncol;
				win_q[2] <= ncol;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= ncol;
			end
		end
	end

	// Interpolate the one or two finished pixels
	always_comb begin
		pair.two             = ctl_s1.two;
		pair.r0.color        = interp(win_q[1], win_q[2], ncol,
					ctl_s1.odd_row, !ctl_s1.odd_col);
		pair.r0.end_of_line  = 1'b0;
		pair.r0.end_of_frame = 1'b0;
		pair.r1.color        = interp(win_q[2], ncol, ncol,
					ctl_s1.odd_row, ctl_s1.odd_col);
		pair.r1.end_of_line  = 1'b1;
		pair.r1.end_of_frame = ctl_s1.drain;
	end

	assign push = valid_s1 && ctl_s1.adv && !ctl_s1.fill;

	bbd_result_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (pair),
		.level     (level),
		.rgb       (rgb)
	);

	// Checks
	`BBD_ASSERT_IMPL(a_fill_not_last, valid_s1 && ctl_s1.fill, !ctl_s1.two)
	`BBD_ASSERT_IMPL(a_level_bound, 1'b1, level <= RES_CNT_W'(RES_DEPTH))
	`BBD_ASSERT_IMPL(a_eof_is_eol, rgb.valid && rgb.end_of_frame, rgb.end_of_line)
	`BBD_ASSERT_NEXT(a_cfg_restart, cfg_wr, col_q == '0 && row_q == '0 && !draining_q)

endmodule

// File: rtl/bbd_result_fifo.sv
// ----------------------------------------------------------------------------
// Bayer demosaic result queue
// Stores result pairs and hands them out one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbd_result_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  bbd_pkg::res_pair_t                push_data,
	output logic [bbd_pkg::RES_CNT_W-1:0]     level,
	bbd_out_if.source                         rgb
);
	import bbd_pkg::*;

	res_pair_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_ptr_q;
	logic [RES_PTR_W-1:0]   rd_ptr_q;
	logic [RES_CNT_W-1:0]   cnt_q;
	logic                   half_q;
	res_pair_t              head;
	res_t                   cur;
	logic                   xfer;
	logic                   pop;

	// Present the head result
	assign head = mem[rd_ptr_q];
	assign cur  = half_q ? head.r1 : head.r0;
	assign rgb.valid        = (cnt_q != '0);
	assign rgb.red          = cur.color.red;
	assign rgb.green        = cur.color.green;
	assign rgb.blue         = cur.color.blue;
	assign rgb.end_of_line  = cur.end_of_line;
	assign rgb.end_of_frame = cur.end_of_frame;
	assign level            = cnt_q;

	assign xfer = rgb.valid && rgb.ready;
	assign pop  = xfer && (!head.two || half_q);

	// Store pairs
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			half_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (xfer) begin
				half_q <= !pop;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: bench/tb_bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bayer bilinear demosaic testbench
// Streams RGGB frames of many sizes into the block and checks every RGB
// pixel against a cycle-free model of the line stores and 3x3 window.
// Covers the reset geometry, clamped and masked register values, drain
// ticks, ignored items, cut frames and random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_bayer_bilinear_demosaic;

	import bbd_pkg::*;

	localparam int unsigned RANDOM_ITEMS   = 150;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned WHOLE_FRAME    = 32'hFFFF_FFFF;
	localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

	// ------------------------------------------------------------------------
	// Demosaic scoreboard: tracks line stores and window, holds expected pixels
	// ------------------------------------------------------------------------
	class demosaic_scoreboard;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		pix_t        line_two_up[MAX_WIDTH];
		pix_t        line_one_up[MAX_WIDTH];
		pix_t        win[3][3];
		int unsigned col_pos;
		int unsigned row_pos;
		int unsigned drain_pos;
		bit          draining;
		res_t        rgb_expected[$];
		int unsigned errors;
		int unsigned inputs_seen;
		int unsigned results_seen;
		int unsigned frames_done;

		function new();
			width_reg  = WIDTH_REG_W'(WIDTH_RESET);
			height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
			foreach (line_two_up[i]) begin
				line_two_up[i] = '0;
				line_one_up[i] = '0;
			end
			foreach (win[r, c]) win[r][c] = '0;
			col_pos   = 0;
			row_pos   = 0;
			drain_pos = 0;
			draining  = 1'b0;
			errors = 0;
			inputs_seen = 0;
			results_seen = 0;
			frames_done = 0;
		endfunction

		function int unsigned eff_w();
			int unsigned v;
			v = width_reg;
			if (v < MIN_DIM) v = MIN_DIM;
			if (v > MAX_WIDTH) v = MAX_WIDTH;
			return v;
		endfunction

		function int unsigned eff_h();
			int unsigned v;
			v = height_reg;
			if (v < MIN_DIM) v = MIN_DIM;
			if (v > MAX_HEIGHT) v = MAX_HEIGHT;
			return v;
		endfunction

		function int unsigned pending_count();
			return rgb_expected.size();
		endfunction

		// Store a register and restart the frame position
		function void write_reg(logic idx, logic [APB_DW-1:0] data);
			if (idx == REG_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
			else height_reg = data[HEIGHT_REG_W-1:0];
			col_pos   = 0;
			row_pos   = 0;
			drain_pos = 0;
			draining  = 1'b0;
		endfunction

		// Interpolate the window center and queue it
		function void queue_pixel(int unsigned row, int unsigned col,
					  int unsigned w, int unsigned h);
			int unsigned cross_v, diag, horiz, vert;
			pix_t ctr;
			res_t want;
			ctr     = win[1][1];
			cross_v = (32'(win[0][1]) + 32'(win[2][1]) + 32'(win[1][0])
				+ 32'(win[1][2]) + 2) >> 2;
			diag    = (32'(win[0][0]) + 32'(win[0][2]) + 32'(win[2][0])
				+ 32'(win[2][2]) + 2) >> 2;
			horiz   = (32'(win[1][0]) + 32'(win[1][2]) + 1) >> 1;
			vert    = (32'(win[0][1]) + 32'(win[2][1]) + 1) >> 1;
			case ({row[0], col[0]})
				2'b00: begin
					want.color.red   = ctr;
					want.color.green = cross_v[7:0];
					want.color.blue  = diag[7:0];
				end
				2'b11: begin
					want.color.red   = diag[7:0];
					want.color.green = cross_v[7:0];
					want.color.blue  = ctr;
				end
				2'b01: begin
					want.color.red   = horiz[7:0];
					want.color.green = ctr;
					want.color.blue  = vert[7:0];
				end
				default: begin
					want.color.red   = vert[7:0];
					want.color.green = ctr;
					want.color.blue  = horiz[7:0];
				end
			endcase
			want.end_of_line  = (col == w - 1);
			want.end_of_frame = (col == w - 1) && (row == h - 1);
			rgb_expected.push_back(want);
		endfunction

		// Move one column into the window; emit the pixels it completes
		function void slide_window(int unsigned col, pix_t t, pix_t m, pix_t b,
					   int unsigned orow, int unsigned w, int unsigned h);
			pix_t v[3];
			v[0] = t;
			v[1] = m;
			v[2] = b;
			if (col == 0) begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++) win[r][c] = v[r];
				return;
			end
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
				win[r][2] = v[r];
			end
			queue_pixel(orow, col - 1, w, h);
			// Last column: replicate it and emit the edge pixel too
			if (col == w - 1) begin
				for (int r = 0; r < 3; r++) begin
					win[r][0] = win[r][1];
					win[r][1] = win[r][2];
					win[r][2] = v[r];
				end
				queue_pixel(orow, col, w, h);
			end
		endfunction

		// Note one accepted input transfer
		function void note_input(logic kind, pix_t smp);
			int unsigned w, h, c, d;
			pix_t t, m;
			w = eff_w();
			h = eff_h();
			inputs_seen++;
			if (kind == KIND_RAW) begin
				// Drop raw samples while the last row drains
				if (draining || col_pos >= w) return;
				c = col_pos;
				if (row_pos == 0) begin
					line_two_up[c] = smp;
					line_one_up[c] = smp;
				end else begin
					t = line_two_up[c];
					m = line_one_up[c];
					line_two_up[c] = m;
					line_one_up[c] = smp;
					slide_window(c, t, m, smp, row_pos - 1, w, h);
				end
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= h) begin
						row_pos   = 0;
						drain_pos = 0;
						draining  = 1'b1;
					end
				end
			end else begin
				// Drop drain ticks outside the drain
				if (!draining || drain_pos >= w) return;
				d = drain_pos;
				slide_window(d, line_two_up[d], line_one_up[d], line_one_up[d],
					     h - 1, w, h);
				drain_pos++;
				if (drain_pos >= w) begin
					drain_pos = 0;
					draining  = 1'b0;
					frames_done++;
				end
			end
		endfunction

		// Compare one output transfer with the oldest expected pixel
		function void check_result(pix_t red, pix_t green, pix_t blue,
					   logic eol, logic eof);
			res_t want;
			results_seen++;
			if (rgb_expected.size() == 0) begin
				$error("unexpected RGB result: red %0d green %0d blue %0d eol %0b eof %0b",
				       red, green, blue, eol, eof);
				errors++;
				return;
			end
			want = rgb_expected.pop_front();
			if (red !== want.color.red) begin
				$error("red: expected %0d, actual %0d", want.color.red, red);
				errors++;
			end
			if (green !== want.color.green) begin
				$error("green: expected %0d, actual %0d", want.color.green, green);
				errors++;
			end
			if (blue !== want.color.blue) begin
				$error("blue: expected %0d, actual %0d", want.color.blue, blue);
				errors++;
			end
			if (eol !== want.end_of_line) begin
				$error("end_of_line: expected %0b, actual %0b", want.end_of_line, eol);
				errors++;
			end
			if (eof !== want.end_of_frame) begin
				$error("end_of_frame: expected %0b, actual %0b", want.end_of_frame, eof);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bbd_in_if  bayer_if();
	bbd_out_if rgb_if();

	demosaic_scoreboard sb;
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;
	int unsigned items_sent;
	int unsigned cfg_writes;
	int unsigned quiet_cycles;

	bayer_bilinear_demosaic i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bayer   (bayer_if),
		.rgb     (rgb_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock
	always #5 clk = ~clk;

	// Sink side: check transfers, toggle ready at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (rgb_if.valid && rgb_if.ready)
				sb.check_result(rgb_if.red, rgb_if.green, rgb_if.blue,
						rgb_if.end_of_line, rgb_if.end_of_frame);
			rgb_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((bayer_if.valid && bayer_if.ready) || (rgb_if.valid && rgb_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Send one item, with a random gap ahead of it
	task automatic send_bayer(input logic kind, input pix_t smp);
		while ($urandom_range(99) < src_idle_pct) begin
			bayer_if.valid <= 1'b0;
			@(posedge clk);
		end
		bayer_if.valid      <= 1'b1;
		bayer_if.kind       <= kind;
		bayer_if.raw_sample <= smp;
		@(posedge clk);
		while (!bayer_if.ready) @(posedge clk);
		sb.note_input(kind, smp);
		items_sent++;
	endtask

	// Hold the sender until every expected pixel has arrived
	task automatic await_rgb();
		bayer_if.valid <= 1'b0;
		do @(posedge clk); while (sb.pending_count() != 0);
	endtask

	// One APB write: setup cycle, then access cycle
	task automatic write_dim_reg(input logic idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= (idx == REG_WIDTH) ? ADDR_WIDTH : ADDR_HEIGHT;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Let the block go idle, then program both dimensions
	task automatic set_dims(input logic [APB_DW-1:0] w_val, input logic [APB_DW-1:0] h_val);
		await_rgb();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_dim_reg(REG_WIDTH, w_val);
		write_dim_reg(REG_HEIGHT, h_val);
	endtask

	// Stream a frame of random samples and its drain ticks, stopping after cut items
	task automatic stream_frame(input int unsigned w, input int unsigned h,
				    input int unsigned cut, input bit noisy);
		int unsigned n;
		n = 0;
		for (int unsigned r = 0; r < h; r++) begin
			for (int unsigned c = 0; c < w; c++) begin
				if (n == cut) return;
				// Stray drain tick mid-frame: dropped by the block
				if (noisy && $urandom_range(99) < 3)
					send_bayer(KIND_DRAIN, pix_t'($urandom));
				if (noisy && $urandom_range(199) == 0) await_rgb();
				send_bayer(KIND_RAW, pix_t'($urandom_range(255)));
				n++;
			end
		end
		for (int unsigned d = 0; d < w; d++) begin
			if (n == cut) return;
			// Stray raw sample during the drain: dropped by the block
			if (noisy && $urandom_range(99) < 3)
				send_bayer(KIND_RAW, pix_t'($urandom_range(255)));
			send_bayer(KIND_DRAIN, pix_t'($urandom));
			n++;
		end
	endtask

	// Random frames of small sizes, some cut short, some back to back
	task automatic random_phase(input int unsigned quota);
		int unsigned start, cut, keep_src, keep_snk;
		logic [APB_DW-1:0] w_val, h_val;
		bit restart;
		start = items_sent;
		restart = 1'b1;
		while (items_sent - start < quota) begin
			if (restart || $urandom_range(9) != 0) begin
				w_val = ($urandom_range(7) == 0) ? $urandom_range(16, 9)
					: $urandom_range(8, 2);
				h_val = $urandom_range(6, 2);
				if ($urandom_range(15) == 0) w_val = $urandom_range(1);
				if ($urandom_range(15) == 0) h_val = $urandom_range(1);
				// Junk in the upper bits is masked off by the register
				if ($urandom_range(7) == 0) begin
					w_val = w_val | ($urandom & 32'hFFFF_F800);
					h_val = h_val | ($urandom & 32'hFFFF_E000);
				end
				set_dims(w_val, h_val);
			end
			cut = WHOLE_FRAME;
			restart = 1'b0;
			if ($urandom_range(6) == 0) begin
				cut = $urandom_range(sb.eff_w() * (sb.eff_h() + 1) - 1);
				restart = 1'b1;
			end
			keep_src = src_idle_pct;
			keep_snk = snk_idle_pct;
			if ($urandom_range(4) == 0) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			stream_frame(sb.eff_w(), sb.eff_h(), cut, 1'b1);
			src_idle_pct = keep_src;
			snk_idle_pct = keep_snk;
		end
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		bayer_if.valid = 1'b0;
		bayer_if.kind = KIND_RAW;
		bayer_if.raw_sample = '0;
		rgb_if.ready = 1'b0;
		items_sent = 0;
		cfg_writes = 0;
		quiet_cycles = 0;
		src_idle_pct = 27;
		snk_idle_pct = 67;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: one row at the default width, then the start of the next
		stream_frame(sb.eff_w(), sb.eff_h(), sb.eff_w() + 8, 1'b0);

		// Smallest frame with extreme samples and dropped items
		set_dims(2, 2);
		send_bayer(KIND_DRAIN, 8'hA5);
		send_bayer(KIND_RAW, 8'hFF);
		send_bayer(KIND_RAW, 8'h00);
		send_bayer(KIND_RAW, 8'h00);
		send_bayer(KIND_RAW, 8'hFF);
		await_rgb();
		send_bayer(KIND_RAW, 8'hFF);
		send_bayer(KIND_DRAIN, 8'h00);
		send_bayer(KIND_DRAIN, 8'hFF);
		send_bayer(KIND_DRAIN, 8'h5A);

		// Dimensions below the minimum clamp to 2x2
		set_dims(1, 0);
		send_bayer(KIND_RAW, 8'h00);
		send_bayer(KIND_RAW, 8'hFF);
		send_bayer(KIND_RAW, 8'hFF);
		send_bayer(KIND_RAW, 8'h00);
		send_bayer(KIND_DRAIN, 8'h00);
		send_bayer(KIND_DRAIN, 8'h00);

		// Upper bits beyond the register width are dropped: 3x2
		set_dims(32'hFFFF_F803, 32'hFFFF_E002);
		for (int i = 0; i < 6; i++)
			send_bayer(KIND_RAW, ((i % 3) == 1) ? 8'h00 : 8'hFF);
		for (int i = 0; i < 3; i++)
			send_bayer(KIND_DRAIN, 8'hFF);

		random_phase(RANDOM_ITEMS / 3);

		// Swap the stall pattern
		src_idle_pct = 67;
		snk_idle_pct = 27;
		// Width 4096 masks to zero and clamps to two
		set_dims(MAX_HEIGHT, 2);
		stream_frame(sb.eff_w(), sb.eff_h(), WHOLE_FRAME, 1'b0);
		// Tallest frame: the first rows must not close the frame
		set_dims(2, MAX_HEIGHT);
		stream_frame(sb.eff_w(), sb.eff_h(), 12, 1'b0);
		random_phase(RANDOM_ITEMS / 3);

		// No stalls at all
		src_idle_pct = 0;
		snk_idle_pct = 0;
		set_dims(0, 8191);
		stream_frame(sb.eff_w(), sb.eff_h(), 12, 1'b0);
		random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		// Flush and let the pipeline go quiet
		await_rgb();
		repeat (20) @(posedge clk);

		if (sb.pending_count() != 0) begin
			$error("%0d expected RGB results never arrived", sb.pending_count());
			sb.errors++;
		end
		$display("Run covered %0d input transfers and %0d RGB results in %0d full frames,",
			 sb.inputs_seen, sb.results_seen, sb.frames_done);
		$display("with %0d register writes including masked, clamped and oversized sizes.",
			 cfg_writes);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
